FILE: rtl/core/sha1d_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1d_pkg
// shared constants and control types of the sha-1 digest core
// ----------------------------------------------------------------------------
package sha1d_pkg;

   localparam int unsigned WordWidth  = 32;
   localparam int unsigned ChainDepth = 5;
   localparam int unsigned SchedDepth = 16;
   localparam int unsigned CountWidth = 61;
   localparam int unsigned PosWidth   = 6;
   localparam int unsigned NumRounds  = 80;

   localparam logic [7:0] PAD_MARKER = 8'h80;

   localparam logic [31:0] K_ROUND0 = 32'h5A827999;
   localparam logic [31:0] K_ROUND1 = 32'h6ED9EBA1;
   localparam logic [31:0] K_ROUND2 = 32'h8F1BBCDC;
   localparam logic [31:0] K_ROUND3 = 32'hCA62C1D6;

   // byte source for the block packer
   localparam logic [1:0] BSEL_MSG  = 2'd0;
   localparam logic [1:0] BSEL_MARK = 2'd1;
   localparam logic [1:0] BSEL_ZERO = 2'd2;
   localparam logic [1:0] BSEL_LEN  = 2'd3;

   // round function group
   localparam logic [1:0] PH_CH     = 2'd0;
   localparam logic [1:0] PH_PAR1   = 2'd1;
   localparam logic [1:0] PH_MAJ    = 2'd2;
   localparam logic [1:0] PH_PAR2   = 2'd3;

   typedef struct packed {
      logic       push;        // pack one byte into the block
      logic [1:0] byte_sel;
      logic       count_inc;   // message byte counted
      logic       load_work;   // working vars from chain
      logic       round_en;
      logic [1:0] round_phase;
      logic       expand;      // schedule word from recurrence
      logic       add_chain;
      logic       emit_shift;
      logic       reinit;
   } dp_cmd_type;

   typedef struct packed {
      logic [PosWidth-1:0] pos;
   } dp_status_type;

   function automatic logic [31:0] init_word(input logic [2:0] idx);
      logic [31:0] w;
      case (idx)
         3'd0:    w = 32'h67452301;
         3'd1:    w = 32'hEFCDAB89;
         3'd2:    w = 32'h98BADCFE;
         3'd3:    w = 32'h10325476;
         3'd4:    w = 32'hC3D2E1F0;
         default: w = 32'h0;
      endcase
      return w;
   endfunction

   function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
      return (x << n) | (x >> (32 - n));
   endfunction

endpackage

FILE: rtl/core/sha1d_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1d_datapath
// byte packer, rolling schedule, round unit, chaining value and byte counter
// ----------------------------------------------------------------------------
module sha1d_datapath (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [7:0]               data_byte,
   input  sha1d_pkg::dp_cmd_type    cmd,
   output sha1d_pkg::dp_status_type status,
   output logic [31:0]              digest_word
);
   import sha1d_pkg::*;

   logic [PosWidth-1:0]   pos_ff, pos_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic [31:0]           acc_ff, acc_in;
   logic [31:0]           sched_ff [SchedDepth];
   logic [31:0]           sched_in [SchedDepth];
   logic [31:0]           a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [31:0]           a_in, b_in, c_in, d_in, e_in;
   logic [31:0]           chain_ff [ChainDepth];
   logic [31:0]           chain_in [ChainDepth];

   logic [63:0] len_bits;
   logic [7:0]  len_byte;
   logic [7:0]  push_byte;
   logic [31:0] push_word;
   logic        word_done;
   logic [31:0] sched_m;
   logic [31:0] f_val, k_val, t_val;

   assign len_bits  = {count_ff, 3'b000};
   assign len_byte  = len_bits[{~pos_ff[2:0], 3'b000} +: 8];

   always_comb begin
      case (cmd.byte_sel)
         BSEL_MSG:  push_byte = data_byte;
         BSEL_MARK: push_byte = PAD_MARKER;
         BSEL_LEN:  push_byte = len_byte;
         default:   push_byte = 8'h00;
      endcase
   end

   assign push_word = {acc_ff[23:0], push_byte};
   assign word_done = cmd.push && (pos_ff[1:0] == 2'b11);

   assign sched_m = cmd.expand ?
      rotl(sched_ff[13] ^ sched_ff[8] ^ sched_ff[2] ^ sched_ff[0], 1) : sched_ff[0];

   always_comb begin
      case (cmd.round_phase)
         PH_CH: begin
            f_val = (b_ff & c_ff) | (~b_ff & d_ff);
            k_val = K_ROUND0;
         end
         PH_PAR1: begin
            f_val = b_ff ^ c_ff ^ d_ff;
            k_val = K_ROUND1;
         end
         PH_MAJ: begin
            f_val = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff);
            k_val = K_ROUND2;
         end
         default: begin
            f_val = b_ff ^ c_ff ^ d_ff;
            k_val = K_ROUND3;
         end
      endcase
   end

   assign t_val = rotl(a_ff, 5) + f_val + e_ff + k_val + sched_m;

   // packer and counter
   always_comb begin
      pos_in   = pos_ff;
      acc_in   = acc_ff;
      count_in = count_ff;
      if (cmd.push) begin
         pos_in = pos_ff + 1'b1;
         acc_in = push_word;
      end
      if (cmd.reinit) begin
         count_in = '0;
      end else if (cmd.count_inc) begin
         count_in = count_ff + 1'b1;
      end
   end

   // schedule shift line, oldest word at tap 0
   always_comb begin
      for (int i = 0; i < SchedDepth; i++) begin
         sched_in[i] = sched_ff[i];
      end
      if (word_done || cmd.round_en) begin
         for (int i = 0; i < SchedDepth - 1; i++) begin
            sched_in[i] = sched_ff[i+1];
         end
         sched_in[SchedDepth-1] = word_done ? push_word : sched_m;
      end
   end

   always_comb begin
      a_in = a_ff;
      b_in = b_ff;
      c_in = c_ff;
      d_in = d_ff;
      e_in = e_ff;
      if (cmd.load_work) begin
         a_in = chain_ff[0];
         b_in = chain_ff[1];
         c_in = chain_ff[2];
         d_in = chain_ff[3];
         e_in = chain_ff[4];
      end else if (cmd.round_en) begin
         a_in = t_val;
         b_in = a_ff;
         c_in = rotl(b_ff, 30);
         d_in = c_ff;
         e_in = d_ff;
      end
   end

   always_comb begin
      for (int i = 0; i < ChainDepth; i++) begin
         chain_in[i] = chain_ff[i];
      end
      if (cmd.reinit) begin
         for (int i = 0; i < ChainDepth; i++) begin
            chain_in[i] = init_word(3'(i));
         end
      end else if (cmd.add_chain) begin
         chain_in[0] = chain_ff[0] + a_ff;
         chain_in[1] = chain_ff[1] + b_ff;
         chain_in[2] = chain_ff[2] + c_ff;
         chain_in[3] = chain_ff[3] + d_ff;
         chain_in[4] = chain_ff[4] + e_ff;
      end else if (cmd.emit_shift) begin
         for (int i = 0; i < ChainDepth - 1; i++) begin
            chain_in[i] = chain_ff[i+1];
         end
         chain_in[ChainDepth-1] = chain_ff[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         count_ff <= '0;
         for (int i = 0; i < ChainDepth; i++) begin
            chain_ff[i] <= init_word(3'(i));
         end
      end else begin
         pos_ff   <= pos_in;
         count_ff <= count_in;
         for (int i = 0; i < ChainDepth; i++) begin
            chain_ff[i] <= chain_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      c_ff   <= c_in;
      d_ff   <= d_in;
      e_ff   <= e_in;
      for (int i = 0; i < SchedDepth; i++) begin
         sched_ff[i] <= sched_in[i];
      end
   end

   assign status.pos  = pos_ff;
   assign digest_word = chain_ff[0];

endmodule

FILE: rtl/core/sha1d_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1d_ctrl
// sequencer for byte intake, padding, compression rounds and digest output
// ----------------------------------------------------------------------------
module sha1d_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic                     req_tuser,
   input  logic                     req_tlast,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic                     rsp_tlast,
   output sha1d_pkg::dp_cmd_type    cmd,
   input  sha1d_pkg::dp_status_type status
);
   import sha1d_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_PAD   = 3'd1;
   localparam logic [2:0] S_ROUND = 3'd2;
   localparam logic [2:0] S_ADD   = 3'd3;
   localparam logic [2:0] S_EMIT  = 3'd4;

   localparam logic [6:0] LAST_ROUND = 7'(NumRounds - 1);
   localparam logic [2:0] LAST_WORD  = 3'(ChainDepth - 1);

   logic [2:0] state_ff, state_in;
   logic [6:0] round_ff, round_in;
   logic [2:0] emit_ff, emit_in;
   logic       pad_active_ff, pad_active_in;
   logic       marker_done_ff, marker_done_in;
   logic       extra_blk_ff, extra_blk_in;
   logic       final_ff, final_in;

   logic req_xfer, rsp_xfer, blk_full, len_zone;

   assign req_xfer = req_tvalid && req_tready;
   assign rsp_xfer = rsp_tvalid && rsp_tready;
   assign blk_full = (status.pos == '1);
   assign len_zone = (status.pos >= PosWidth'(56));

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_EMIT);
   assign rsp_tlast  = (emit_ff == LAST_WORD);

   always_comb begin
      state_in       = state_ff;
      round_in       = round_ff;
      emit_in        = emit_ff;
      pad_active_in  = pad_active_ff;
      marker_done_in = marker_done_ff;
      extra_blk_in   = extra_blk_ff;
      final_in       = final_ff;
      cmd            = '0;
      cmd.byte_sel   = BSEL_MSG;

      if (round_ff < 7'd20) begin
         cmd.round_phase = PH_CH;
      end else if (round_ff < 7'd40) begin
         cmd.round_phase = PH_PAR1;
      end else if (round_ff < 7'd60) begin
         cmd.round_phase = PH_MAJ;
      end else begin
         cmd.round_phase = PH_PAR2;
      end
      cmd.expand = (round_ff >= 7'(SchedDepth));

      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               if (req_tlast) begin
                  pad_active_in  = 1'b1;
                  marker_done_in = 1'b0;
                  extra_blk_in   = 1'b0;
                  final_in       = 1'b0;
                  state_in       = S_PAD;
               end
               if (req_tuser) begin
                  cmd.push      = 1'b1;
                  cmd.count_inc = 1'b1;
                  if (blk_full) begin
                     cmd.load_work = 1'b1;
                     state_in      = S_ROUND;
                  end
               end
            end
         end
         S_PAD: begin
            cmd.push = 1'b1;
            if (!marker_done_ff) begin
               cmd.byte_sel   = BSEL_MARK;
               marker_done_in = 1'b1;
               extra_blk_in   = len_zone;
            end else if (len_zone && !extra_blk_ff) begin
               cmd.byte_sel = BSEL_LEN;
            end else begin
               cmd.byte_sel = BSEL_ZERO;
            end
            if (blk_full) begin
               // a marker too late for the length pushes it into a spare block
               extra_blk_in  = 1'b0;
               final_in      = (cmd.byte_sel == BSEL_LEN);
               cmd.load_work = 1'b1;
               state_in      = S_ROUND;
            end
         end
         S_ROUND: begin
            cmd.round_en = 1'b1;
            if (round_ff == LAST_ROUND) begin
               round_in = '0;
               state_in = S_ADD;
            end else begin
               round_in = round_ff + 1'b1;
            end
         end
         S_ADD: begin
            cmd.add_chain = 1'b1;
            if (final_ff) begin
               state_in = S_EMIT;
            end else if (pad_active_ff) begin
               state_in = S_PAD;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_EMIT: begin
            if (rsp_xfer) begin
               if (emit_ff == LAST_WORD) begin
                  cmd.reinit    = 1'b1;
                  emit_in       = '0;
                  pad_active_in = 1'b0;
                  final_in      = 1'b0;
                  state_in      = S_IDLE;
               end else begin
                  cmd.emit_shift = 1'b1;
                  emit_in        = emit_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         round_ff       <= '0;
         emit_ff        <= '0;
         pad_active_ff  <= 1'b0;
         marker_done_ff <= 1'b0;
         extra_blk_ff   <= 1'b0;
         final_ff       <= 1'b0;
      end else begin
         state_ff       <= state_in;
         round_ff       <= round_in;
         emit_ff        <= emit_in;
         pad_active_ff  <= pad_active_in;
         marker_done_ff <= marker_done_in;
         extra_blk_ff   <= extra_blk_in;
         final_ff       <= final_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_round_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_ROUND) |-> (round_ff == '0))
      else $error("round counter busy outside compression");

   a_emit_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_EMIT) |-> (emit_ff == '0))
      else $error("digest word counter busy outside output");

   a_full_compress: assert property (@(posedge clock) disable iff (reset)
      (cmd.push && blk_full) |=> (state_ff == S_ROUND))
      else $error("full block not compressed");

   a_final_emit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ADD && final_ff) |=> (state_ff == S_EMIT))
      else $error("final block did not lead to digest output");
`endif

endmodule

FILE: rtl/core/sha1_message_digest_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_message_digest_core
// sha-1 digest over a byte stream, five digest words out per message
// ----------------------------------------------------------------------------
//  channel | dir | transfer content
//  req_    | in  | tdata = data_byte, tuser = byte_present, tlast = end_of_message
//  rsp_    | out | tdata = digest_word (h0 first), tlast = last_word
//
//  each message byte is packed as it is transferred; the 64th byte of a block
//  starts the round loop, followed by the chain update
//  end of message: padding bytes go through the packer one per cycle, with one
//  or two further compressions, then five digest transfers
//  reset: synchronous, active high; chain value and byte count start afresh
//  req_tready is low during rounds, padding and output; rsp stalls hold
// ----------------------------------------------------------------------------
module sha1_message_digest_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] byte_present
   input  logic        req_tlast,   // end_of_message
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] digest_word
   output logic        rsp_tlast    // last_word
);
   import sha1d_pkg::*;

   // command and status between sequencer and datapath
   dp_cmd_type    cmd;
   dp_status_type status;

   // sequencer: intake, padding order, round count, output count
   sha1d_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tlast  (rsp_tlast),
      .cmd        (cmd),
      .status     (status)
   );

   // datapath: packer, schedule shift line, round unit, chain registers
   sha1d_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .data_byte   (req_tdata),
      .cmd         (cmd),
      .status      (status),
      .digest_word (rsp_tdata)
   );

endmodule
